// ----- sv/aapr_pkg.sv -----
// Package with shared widths, constants and the arctangent table of the rotation core.
package aapr_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned AxisW     = 18;
  localparam int unsigned AngleW    = 19;
  localparam int unsigned CordicW   = 34;
  localparam int unsigned TableLen  = 24;
  localparam int unsigned DefSteps  = 16;
  localparam int unsigned MatW      = 36;
  localparam int unsigned EntryW    = 30;

  localparam logic signed [CordicW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordicW-1:0] OneQ30    = 34'sd1073741824;
  localparam logic signed [CordicW-1:0] GainQ30   = 34'sd652032874;

  // Arctangent of two to the minus i, in Q2.30, rounded to nearest.
  function automatic logic signed [CordicW-1:0] atan_q30(input int unsigned idx);
    logic signed [CordicW-1:0] r;
    case (idx)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Geometry carried alongside the angle while the sine and cosine are formed.
  typedef struct packed {
    logic signed [CoordW-1:0] cen_x;
    logic signed [CoordW-1:0] cen_y;
    logic signed [CoordW-1:0] cen_z;
    logic signed [CoordW:0]   d_x;
    logic signed [CoordW:0]   d_y;
    logic signed [CoordW:0]   d_z;
    logic signed [AxisW-1:0]  u_x;
    logic signed [AxisW-1:0]  u_y;
    logic signed [AxisW-1:0]  u_z;
  } geom_t;

endpackage

// ----- sv/aapr_cordic.sv -----
// Pipelined rotation-mode CORDIC, one step per stage, carrying the geometry along.
module aapr_cordic #(
  parameter int unsigned Steps = aapr_pkg::DefSteps
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic signed [aapr_pkg::AngleW-1:0]      angle_i,
  input  aapr_pkg::geom_t                         geom_i,
  output logic                                    valid_o,
  output logic signed [aapr_pkg::CordicW-1:0]     cos_o,
  output logic signed [aapr_pkg::CordicW-1:0]     sin_o,
  output aapr_pkg::geom_t                         geom_o
);

  localparam int unsigned N = (Steps > aapr_pkg::TableLen) ? aapr_pkg::TableLen : Steps;

  logic                                 vld_q  [N+1];
  logic signed [aapr_pkg::CordicW-1:0]  x_q    [N+1];
  logic signed [aapr_pkg::CordicW-1:0]  y_q    [N+1];
  logic signed [aapr_pkg::CordicW-1:0]  z_q    [N+1];
  logic                                 flip_q [N+1];
  aapr_pkg::geom_t                      geom_q [N+1];

  logic signed [aapr_pkg::CordicW-1:0]  z_in;
  logic signed [aapr_pkg::CordicW-1:0]  z_d;
  logic                                 flip_d;

  // Range reduction of the angle into minus to plus half pi.
  always_comb begin
    z_in   = {{(aapr_pkg::CordicW-aapr_pkg::AngleW-14){angle_i[aapr_pkg::AngleW-1]}},
              angle_i, 14'd0};
    z_d    = z_in;
    flip_d = 1'b0;
    if (z_in > aapr_pkg::HalfPiQ30) begin
      z_d    = z_in - aapr_pkg::PiQ30;
      flip_d = 1'b1;
    end else if (z_in < -aapr_pkg::HalfPiQ30) begin
      z_d    = z_in + aapr_pkg::PiQ30;
      flip_d = 1'b1;
    end
  end

  // Entry stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= aapr_pkg::GainQ30;
    y_q[0]    <= '0;
    z_q[0]    <= z_d;
    flip_q[0] <= flip_d;
    geom_q[0] <= geom_i;
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - aapr_pkg::atan_q30(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + aapr_pkg::atan_q30(i);
      end
      flip_q[i+1] <= flip_q[i];
      geom_q[i+1] <= geom_q[i];
    end
  end

  assign valid_o = vld_q[N];
  assign cos_o   = flip_q[N] ? -x_q[N] : x_q[N];
  assign sin_o   = flip_q[N] ? -y_q[N] : y_q[N];
  assign geom_o  = geom_q[N];

endmodule

// ----- sv/aapr_matrix.sv -----
// Pipelined Rodrigues matrix build, dot products, centre add and saturation.
module aapr_matrix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [aapr_pkg::CordicW-1:0]  cos_i,
  input  logic signed [aapr_pkg::CordicW-1:0]  sin_i,
  input  aapr_pkg::geom_t                      geom_i,
  output logic                                 valid_o,
  output logic signed [aapr_pkg::CoordW-1:0]   rot_x_o,
  output logic signed [aapr_pkg::CoordW-1:0]   rot_y_o,
  output logic signed [aapr_pkg::CoordW-1:0]   rot_z_o,
  output logic                                 clip_o
);

  localparam int unsigned CW = aapr_pkg::CordicW;
  localparam int unsigned MW = aapr_pkg::MatW;
  localparam int unsigned EW = aapr_pkg::EntryW;
  localparam int unsigned PW = 72;

  logic [5:0] vld_q;

  // Stage 1: axis products rounded to Q16, and one minus cosine.
  logic signed [20:0]   uu_q [6];
  logic signed [CW-1:0] t_q, c1_q, s1_q;
  aapr_pkg::geom_t      g1_q;
  logic signed [35:0]   pp [6];

  always_comb begin
    pp[0] = geom_i.u_x * geom_i.u_x;
    pp[1] = geom_i.u_y * geom_i.u_y;
    pp[2] = geom_i.u_z * geom_i.u_z;
    pp[3] = geom_i.u_x * geom_i.u_y;
    pp[4] = geom_i.u_x * geom_i.u_z;
    pp[5] = geom_i.u_y * geom_i.u_z;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      uu_q[k] <= 21'((pp[k] + 36'sd32768) >>> 16);
    end
    t_q  <= aapr_pkg::OneQ30 - cos_i;
    c1_q <= cos_i;
    s1_q <= sin_i;
    g1_q <= geom_i;
  end

  // Stage 2: products with one minus cosine and with sine, rounded to Q30.
  logic signed [MW-1:0] tu_q [6];
  logic signed [MW-1:0] su_q [3];
  logic signed [CW-1:0] c2_q;
  aapr_pkg::geom_t      g2_q;
  logic signed [55:0]   tp [6];
  logic signed [51:0]   sp [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tp[k] = 56'(uu_q[k]) * 56'(t_q);
    end
    sp[0] = 52'(g1_q.u_x) * 52'(s1_q);
    sp[1] = 52'(g1_q.u_y) * 52'(s1_q);
    sp[2] = 52'(g1_q.u_z) * 52'(s1_q);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      tu_q[k] <= MW'((tp[k] + 56'sd32768) >>> 16);
    end
    for (int k = 0; k < 3; k++) begin
      su_q[k] <= MW'((sp[k] + 52'sd32768) >>> 16);
    end
    c2_q <= c1_q;
    g2_q <= g1_q;
  end

  // Stage 3: sum matrix entries in Q30, round to Q24.
  logic signed [EW-1:0] m_q [9];
  aapr_pkg::geom_t      g3_q;
  logic signed [MW-1:0] ms [9];

  always_comb begin
    ms[0] = MW'(c2_q) + tu_q[0];
    ms[1] = tu_q[3] - su_q[2];
    ms[2] = tu_q[4] + su_q[1];
    ms[3] = tu_q[3] + su_q[2];
    ms[4] = MW'(c2_q) + tu_q[1];
    ms[5] = tu_q[5] - su_q[0];
    ms[6] = tu_q[4] - su_q[1];
    ms[7] = tu_q[5] + su_q[0];
    ms[8] = MW'(c2_q) + tu_q[2];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      m_q[k] <= EW'((ms[k] + MW'(32)) >>> 6);
    end
    g3_q <= g2_q;
  end

  // Stage 4: the nine offset by entry products, exact in Q40.
  logic signed [63:0]   dp_q [9];
  aapr_pkg::geom_t      g4_q;
  logic signed [aapr_pkg::CoordW:0] dv [3];

  assign dv[0] = g3_q.d_x;
  assign dv[1] = g3_q.d_y;
  assign dv[2] = g3_q.d_z;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        dp_q[3*j+k] <= 64'(dv[k]) * 64'(m_q[3*j+k]);
      end
    end
    g4_q <= g3_q;
  end

  // Stage 5: row sums rounded to Q16.
  logic signed [47:0]   r_q [3];
  aapr_pkg::geom_t      g5_q;
  logic signed [PW-1:0] acc [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = PW'(dp_q[3*j]) + PW'(dp_q[3*j+1]) + PW'(dp_q[3*j+2])
             + (PW'(1) <<< 23);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      r_q[j] <= 48'(acc[j] >>> 24);
    end
    g5_q <= g4_q;
  end

  // Stage 6: add the centre back and saturate.
  logic signed [aapr_pkg::CoordW-1:0] o_q [3];
  logic                               clip_q;
  logic signed [48:0] sum [3];
  logic signed [aapr_pkg::CoordW-1:0] sat [3];
  logic [2:0] cl;

  always_comb begin
    sum[0] = 49'(r_q[0]) + 49'(g5_q.cen_x);
    sum[1] = 49'(r_q[1]) + 49'(g5_q.cen_y);
    sum[2] = 49'(r_q[2]) + 49'(g5_q.cen_z);
    for (int j = 0; j < 3; j++) begin
      cl[j] = 1'b1;
      if (sum[j] > 49'sd2147483647) begin
        sat[j] = 32'sh7FFFFFFF;
      end else if (sum[j] < -49'sd2147483648) begin
        sat[j] = 32'sh80000000;
      end else begin
        sat[j] = sum[j][31:0];
        cl[j]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      o_q[j] <= sat[j];
    end
    clip_q <= |cl;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign rot_x_o = o_q[0];
  assign rot_y_o = o_q[1];
  assign rot_z_o = o_q[2];
  assign clip_o  = clip_q;

endmodule

// ----- sv/axis_angle_point_rotation_core.sv -----
// Top level of the axis-angle point rotation core.
//
//  channel | handshake         | payload
//  input   | start_i / busy_o  | centre, point, axis, turn angle
//  result  | done_o (strobe)   | rotated x/y/z, clipped
//
// One beat is taken in every cycle; busy_o is always low.
// A beat passes through the entry register, the CORDIC stages, one per step (steps
// capped at 24), and the six matrix and dot product stages.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so results are never held back in the pipeline.
module axis_angle_point_rotation_core #(
  parameter int unsigned CORDIC_STEPS = aapr_pkg::DefSteps
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [aapr_pkg::CoordW-1:0]  center_x_i,
  input  logic signed [aapr_pkg::CoordW-1:0]  center_y_i,
  input  logic signed [aapr_pkg::CoordW-1:0]  center_z_i,
  input  logic signed [aapr_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [aapr_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [aapr_pkg::CoordW-1:0]  point_z_i,
  input  logic signed [aapr_pkg::AxisW-1:0]   axis_x_i,
  input  logic signed [aapr_pkg::AxisW-1:0]   axis_y_i,
  input  logic signed [aapr_pkg::AxisW-1:0]   axis_z_i,
  input  logic signed [aapr_pkg::AngleW-1:0]  turn_angle_i,
  output logic                                done_o,
  output logic signed [aapr_pkg::CoordW-1:0]  rotated_x_o,
  output logic signed [aapr_pkg::CoordW-1:0]  rotated_y_o,
  output logic signed [aapr_pkg::CoordW-1:0]  rotated_z_o,
  output logic                                clipped_o
);

  aapr_pkg::geom_t geom_in, geom_c;
  logic            vld_c;
  logic signed [aapr_pkg::CordicW-1:0] cos_c, sin_c;

  assign busy_o = 1'b0;

  // Offsets from centre to point, one bit wider.
  always_comb begin
    geom_in.cen_x = center_x_i;
    geom_in.cen_y = center_y_i;
    geom_in.cen_z = center_z_i;
    geom_in.d_x   = 33'(point_x_i) - 33'(center_x_i);
    geom_in.d_y   = 33'(point_y_i) - 33'(center_y_i);
    geom_in.d_z   = 33'(point_z_i) - 33'(center_z_i);
    geom_in.u_x   = axis_x_i;
    geom_in.u_y   = axis_y_i;
    geom_in.u_z   = axis_z_i;
  end

  aapr_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .angle_i (turn_angle_i),
    .geom_i  (geom_in),
    .valid_o (vld_c),
    .cos_o   (cos_c),
    .sin_o   (sin_c),
    .geom_o  (geom_c)
  );

  aapr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_c),
    .cos_i   (cos_c),
    .sin_i   (sin_c),
    .geom_i  (geom_c),
    .valid_o (done_o),
    .rot_x_o (rotated_x_o),
    .rot_y_o (rotated_y_o),
    .rot_z_o (rotated_z_o),
    .clip_o  (clipped_o)
  );

endmodule

// ----- sv/aapr_checker.sv -----
// Port checker for the rotation core, bound to the top level.
module aapr_checker #(
  parameter int unsigned CORDIC_STEPS = aapr_pkg::DefSteps
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] rotated_x_o,
  input logic [31:0] rotated_y_o,
  input logic [31:0] rotated_z_o,
  input logic        clipped_o
);

  // Cycles from an accepted beat to its result strobe.
  localparam int unsigned Lat =
    ((CORDIC_STEPS > aapr_pkg::TableLen) ? aapr_pkg::TableLen : CORDIC_STEPS) + 7;

  // Every accepted beat gives its result after the fixed latency.
  a_beat_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Lat done_o) else $error("result missing after beat");

  // The core never pushes back.
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  // No result without a beat taken the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without beat");

  // Done stays low just after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o) else $error("done after reset");

  // A clipped result has at least one coordinate on a rail.
  a_unclipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && clipped_o |-> (rotated_x_o == 32'h7FFFFFFF || rotated_x_o == 32'h80000000
      || rotated_y_o == 32'h7FFFFFFF || rotated_y_o == 32'h80000000
      || rotated_z_o == 32'h7FFFFFFF || rotated_z_o == 32'h80000000))
    else $error("clipped without saturated coordinate");

endmodule

bind axis_angle_point_rotation_core aapr_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .rotated_x_o (rotated_x_o),
  .rotated_y_o (rotated_y_o),
  .rotated_z_o (rotated_z_o),
  .clipped_o   (clipped_o)
);
